// ===== rtl/cqr_pkg.sv =====
// shared types and constants for the circular queue with reverse
package cqr_pkg;

    localparam int CMD_W  = 2;
    localparam int STAT_W = 2;
    localparam int CFG_W  = 4;

    // command codes
    localparam logic [CMD_W-1:0] CMD_ENQ = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DEQ = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REV = 2'd2;

    // result status codes
    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        RSEL_HEAD,
        RSEL_LO,
        RSEL_HI
    } rsel_t;

    typedef enum logic [1:0] {
        WSEL_NONE,
        WSEL_TAIL,
        WSEL_LO,
        WSEL_HI
    } wsel_t;

    // controller to datapath
    typedef struct packed {
        logic                load;
        logic                enq;
        logic                deq;
        logic                rev_init;
        logic                rev_step;
        logic                cap_tmp;
        logic                respond;
        rsel_t               rsel;
        wsel_t               wsel;
        logic [STAT_W-1:0]   status;
    } ctl_t;

    // datapath to controller
    typedef struct packed {
        logic empty;
        logic full;
        logic multi;
        logic pair_last;
    } dp_stat_t;

endpackage

// ===== rtl/cqr_ctrl.sv =====
// controller state machine sequencing each request through the datapath
module cqr_ctrl
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [cqr_pkg::CMD_W-1:0]   cmd,
    input  cqr_pkg::dp_stat_t           stat,
    output logic                        busy,
    output cqr_pkg::ctl_t               ctl
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DQ_RD,
        S_EXEC,
        S_RLO,
        S_RHI,
        S_WLO,
        S_WHI,
        S_HEAD_RD,
        S_RESP
    } state_t;

    state_t                         state_reg, state_next;
    logic [cqr_pkg::CMD_W-1:0]      cmd_reg, cmd_next;
    logic [cqr_pkg::STAT_W-1:0]     status_reg, status_next;
    logic                           busy_reg, busy_next;

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        status_next = status_reg;
        busy_next   = busy_reg;
        ctl         = '0;
        ctl.rsel    = cqr_pkg::RSEL_HEAD;
        ctl.wsel    = cqr_pkg::WSEL_NONE;
        ctl.status  = status_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start && !busy_reg)
                begin
                    ctl.load  = 1'b1;
                    cmd_next  = cmd;
                    busy_next = 1'b1;
                    case (cmd)
                        cqr_pkg::CMD_ENQ:
                        begin
                            status_next = stat.full ? cqr_pkg::ST_FULL : cqr_pkg::ST_DONE;
                            state_next  = stat.full ? S_HEAD_RD : S_EXEC;
                        end
                        cqr_pkg::CMD_DEQ:
                        begin
                            status_next = stat.empty ? cqr_pkg::ST_EMPTY : cqr_pkg::ST_DONE;
                            state_next  = stat.empty ? S_HEAD_RD : S_DQ_RD;
                        end
                        cqr_pkg::CMD_REV:
                        begin
                            status_next = stat.empty ? cqr_pkg::ST_EMPTY : cqr_pkg::ST_DONE;
                            state_next  = stat.multi ? S_EXEC : S_HEAD_RD;
                        end
                        default:
                        begin
                            status_next = cqr_pkg::ST_DONE;
                            state_next  = S_HEAD_RD;
                        end
                    endcase
                end
            end
            S_DQ_RD:
            begin
                ctl.rsel   = cqr_pkg::RSEL_HEAD;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                case (cmd_reg)
                    cqr_pkg::CMD_ENQ:
                    begin
                        ctl.enq    = 1'b1;
                        ctl.wsel   = cqr_pkg::WSEL_TAIL;
                        state_next = S_HEAD_RD;
                    end
                    cqr_pkg::CMD_DEQ:
                    begin
                        ctl.deq    = 1'b1;
                        state_next = S_HEAD_RD;
                    end
                    default:
                    begin
                        ctl.rev_init = 1'b1;
                        state_next   = S_RLO;
                    end
                endcase
            end
            S_RLO:
            begin
                ctl.rsel   = cqr_pkg::RSEL_LO;
                state_next = S_RHI;
            end
            S_RHI:
            begin
                // low word lands now, high word is requested
                ctl.rsel    = cqr_pkg::RSEL_HI;
                ctl.cap_tmp = 1'b1;
                state_next  = S_WLO;
            end
            S_WLO:
            begin
                ctl.wsel   = cqr_pkg::WSEL_LO;
                state_next = S_WHI;
            end
            S_WHI:
            begin
                ctl.wsel     = cqr_pkg::WSEL_HI;
                ctl.rev_step = 1'b1;
                state_next   = stat.pair_last ? S_HEAD_RD : S_RLO;
            end
            S_HEAD_RD:
            begin
                ctl.rsel   = cqr_pkg::RSEL_HEAD;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                ctl.respond = 1'b1;
                busy_next   = 1'b0;
                state_next  = S_IDLE;
            end
            default:
            begin
                busy_next  = 1'b0;
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cmd_reg    <= cqr_pkg::CMD_ENQ;
            status_reg <= cqr_pkg::ST_DONE;
            busy_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cmd_reg    <= cmd_next;
            status_reg <= status_next;
            busy_reg   <= busy_next;
        end
    end

    assign busy = busy_reg;

    a_busy_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg == (state_reg != S_IDLE))
        else $error("busy out of step with controller state");

    a_resp_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RESP |=> state_reg == S_IDLE && !busy_reg)
        else $error("controller did not return to idle after response");

    a_swap_entry_reverse: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RLO |-> cmd_reg == cqr_pkg::CMD_REV)
        else $error("swap sequence entered for a non-reverse request");

endmodule

// ===== rtl/cqr_dpath.sv =====
// datapath: ring storage, pointers, occupancy, capacity register and result registers
module cqr_dpath
#(
    parameter int DEPTH      = 8,
    parameter int DATA_WIDTH = 32
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  cqr_pkg::ctl_t                   ctl,
    input  logic [DATA_WIDTH-1:0]           data_in,
    input  logic                            cfg_we,
    input  logic [cqr_pkg::CFG_W-1:0]       cfg_data,
    output cqr_pkg::dp_stat_t               stat,
    output logic                            done,
    output logic [cqr_pkg::STAT_W-1:0]      status,
    output logic [DATA_WIDTH-1:0]           data_out,
    output logic [DATA_WIDTH-1:0]           head_value,
    output logic                            is_empty,
    output logic                            is_full,
    output logic [$clog2(DEPTH+1)-1:0]      occupancy
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH+1);
    localparam int CMP_W = (CNT_W > cqr_pkg::CFG_W) ? CNT_W : cqr_pkg::CFG_W;

    logic [DATA_WIDTH-1:0]  mem [DEPTH];
    logic [DATA_WIDTH-1:0]  rdata_reg;

    logic [AW-1:0]          head_reg, head_next;
    logic [AW-1:0]          tail_reg, tail_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CNT_W-1:0]       cap_reg, cap_next;
    logic [AW-1:0]          lo_reg, lo_next;
    logic [AW-1:0]          hi_reg, hi_next;
    logic [CNT_W-1:0]       pairs_reg, pairs_next;
    logic [DATA_WIDTH-1:0]  tmp_reg;
    logic [DATA_WIDTH-1:0]  din_reg;
    logic [DATA_WIDTH-1:0]  dout_reg;

    logic                   done_reg;
    logic [cqr_pkg::STAT_W-1:0] status_reg;
    logic [DATA_WIDTH-1:0]  data_out_reg;
    logic [DATA_WIDTH-1:0]  head_value_reg;
    logic                   is_empty_reg;
    logic                   is_full_reg;
    logic [CNT_W-1:0]       occupancy_reg;

    logic [AW-1:0]          raddr;
    logic [AW-1:0]          waddr;
    logic [DATA_WIDTH-1:0]  wdata;
    logic                   we;
    logic [CMP_W-1:0]       cfg_ext;
    logic [CNT_W-1:0]       cap_clamped;

    function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] i,
                                                 input logic [CNT_W-1:0] cap);
        logic [CNT_W-1:0] inc;
        inc = CNT_W'(i) + CNT_W'(1);
        return (inc >= cap) ? '0 : AW'(inc);
    endfunction

    function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] i,
                                                 input logic [CNT_W-1:0] cap);
        logic [CNT_W-1:0] top;
        top = cap - CNT_W'(1);
        return (i == '0) ? AW'(top) : i - AW'(1);
    endfunction

    // out-of-range capacity writes saturate into one to depth
    always_comb
    begin
        cfg_ext = CMP_W'(cfg_data);
        if (cfg_data == '0)
            cap_clamped = CNT_W'(1);
        else if (cfg_ext > CMP_W'(DEPTH))
            cap_clamped = CNT_W'(DEPTH);
        else
            cap_clamped = CNT_W'(cfg_ext);
    end

    always_comb
    begin
        case (ctl.rsel)
            cqr_pkg::RSEL_LO: raddr = lo_reg;
            cqr_pkg::RSEL_HI: raddr = hi_reg;
            default:          raddr = head_reg;
        endcase
        we = 1'b1;
        case (ctl.wsel)
            cqr_pkg::WSEL_TAIL:
            begin
                waddr = tail_reg;
                wdata = din_reg;
            end
            cqr_pkg::WSEL_LO:
            begin
                waddr = lo_reg;
                wdata = rdata_reg;
            end
            cqr_pkg::WSEL_HI:
            begin
                waddr = hi_reg;
                wdata = tmp_reg;
            end
            default:
            begin
                we    = 1'b0;
                waddr = tail_reg;
                wdata = din_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        cap_next   = cap_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        pairs_next = pairs_reg;
        if (cfg_we && count_reg == '0)
        begin
            cap_next  = cap_clamped;
            head_next = '0;
            tail_next = '0;
        end
        if (ctl.enq)
        begin
            tail_next  = ring_next(tail_reg, cap_reg);
            count_next = count_reg + CNT_W'(1);
        end
        if (ctl.deq)
        begin
            head_next  = ring_next(head_reg, cap_reg);
            count_next = count_reg - CNT_W'(1);
        end
        if (ctl.rev_init)
        begin
            lo_next    = head_reg;
            hi_next    = ring_prev(tail_reg, cap_reg);
            pairs_next = count_reg >> 1;
        end
        if (ctl.rev_step)
        begin
            lo_next    = ring_next(lo_reg, cap_reg);
            hi_next    = ring_prev(hi_reg, cap_reg);
            pairs_next = pairs_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            cap_reg   <= CNT_W'(DEPTH);
            lo_reg    <= '0;
            hi_reg    <= '0;
            pairs_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            cap_reg   <= cap_next;
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            pairs_reg <= pairs_next;
            done_reg  <= ctl.respond;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            din_reg  <= data_in;
            dout_reg <= '1;
        end
        if (ctl.deq)
            dout_reg <= rdata_reg;
        if (ctl.cap_tmp)
            tmp_reg <= rdata_reg;
        if (ctl.respond)
        begin
            status_reg     <= ctl.status;
            data_out_reg   <= dout_reg;
            head_value_reg <= (count_reg == '0) ? '1 : rdata_reg;
            is_empty_reg   <= (count_reg == '0);
            is_full_reg    <= (count_reg == cap_reg);
            occupancy_reg  <= count_reg;
        end
    end

    assign stat.empty     = (count_reg == '0);
    assign stat.full      = (count_reg >= cap_reg);
    assign stat.multi     = (count_reg >= CNT_W'(2));
    assign stat.pair_last = (pairs_reg == CNT_W'(1));

    assign done       = done_reg;
    assign status     = status_reg;
    assign data_out   = data_out_reg;
    assign head_value = head_value_reg;
    assign is_empty   = is_empty_reg;
    assign is_full    = is_full_reg;
    assign occupancy  = occupancy_reg;

    a_count_in_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cap_reg)
        else $error("occupancy exceeds capacity in use");

    a_pointers_meet: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == cap_reg) |-> head_reg == tail_reg)
        else $error("head and tail disagree on an empty or full ring");

    a_head_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        CNT_W'(head_reg) < cap_reg && CNT_W'(tail_reg) < cap_reg)
        else $error("ring pointer beyond capacity in use");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held for more than one cycle");

endmodule

// ===== rtl/circular_queue_with_reverse.sv =====
// top level of the circular queue with in-place reverse
//
// a ring of DEPTH words of DATA_WIDTH bits, of which capacity_in_use slots are used.
// a request (cmd, data_in) is taken at a clock edge with start high and busy low;
// cmd 0 enqueues data_in, 1 dequeues the oldest word, 2 reverses the stored order.
// exactly one result follows each request: done is high for one cycle with status,
// data_out, head_value, is_empty, is_full and occupancy, and the receiver cannot
// hold it off. busy falls in the same cycle as done, so the next request may start.
// the ring memory has one read and one write port, and its read is registered;
// a dequeue first reads the head word, and a reverse swaps floor(occupancy/2)
// pairs with one read-read-write-write round each; a rejected request, cmd 3
// and the reverse of a single word go straight to reading the head word.
// the capacity register is written on cfg_valid with cfg_ready, which is high
// whenever the block is not busy; a write is ignored unless the queue is empty,
// and when taken also returns both ring pointers to slot 0. 0 acts as 1, values
// above DEPTH act as DEPTH.
// reset empties the queue and sets capacity to DEPTH; storage is not cleared.
module circular_queue_with_reverse
#(
    parameter int DEPTH      = 8,
    parameter int DATA_WIDTH = 32
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [cqr_pkg::CMD_W-1:0]       cmd,
    input  logic [DATA_WIDTH-1:0]           data_in,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [cqr_pkg::CFG_W-1:0]       cfg_data,
    output logic                            done,
    output logic [cqr_pkg::STAT_W-1:0]      status,
    output logic [DATA_WIDTH-1:0]           data_out,
    output logic [DATA_WIDTH-1:0]           head_value,
    output logic                            is_empty,
    output logic                            is_full,
    output logic [$clog2(DEPTH+1)-1:0]      occupancy
);

    cqr_pkg::ctl_t      ctl;
    cqr_pkg::dp_stat_t  stat;
    logic               busy_int;

    cqr_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .stat  (stat),
        .busy  (busy_int),
        .ctl   (ctl)
    );

    cqr_dpath
    #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    )
    u_dpath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .data_in    (data_in),
        .cfg_we     (cfg_valid && !busy_int),
        .cfg_data   (cfg_data),
        .stat       (stat),
        .done       (done),
        .status     (status),
        .data_out   (data_out),
        .head_value (head_value),
        .is_empty   (is_empty),
        .is_full    (is_full),
        .occupancy  (occupancy)
    );

    assign busy      = busy_int;
    assign cfg_ready = !busy_int;

endmodule

// ===== dv/cq_scoreboard_pkg.sv =====
// queue predictor and result scoreboard for the circular queue with reverse
`timescale 1ns / 100ps

package cq_scoreboard_pkg;

    import cqr_pkg::*;

    localparam int RING_SLOTS = 8;
    localparam int WORD_W     = 32;
    localparam int OCC_W      = 4;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [WORD_W-1:0] data_out;
        logic [WORD_W-1:0] head_value;
        logic              is_empty;
        logic              is_full;
        logic [OCC_W-1:0]  occupancy;
    } queue_result_t;

    class cq_scoreboard;

        logic [WORD_W-1:0] ring_words [RING_SLOTS];
        int unsigned       head_slot;
        int unsigned       tail_slot;
        int unsigned       stored_count;
        int unsigned       capacity;
        queue_result_t     awaited_results [$];
        int unsigned       errors;

        function new();
            foreach (ring_words[i])
                ring_words[i] = '0;
            head_slot    = 0;
            tail_slot    = 0;
            stored_count = 0;
            capacity     = RING_SLOTS;
            errors       = 0;
        endfunction

        function int unsigned next_slot(int unsigned i);
            return (i + 1 >= capacity) ? 0 : i + 1;
        endfunction

        function int unsigned prev_slot(int unsigned i);
            return (i == 0) ? capacity - 1 : i - 1;
        endfunction

        // capacity change only takes effect on an empty queue
        function void set_capacity(logic [CFG_W-1:0] value);
            int unsigned v;
            v = 32'(value);
            if (stored_count != 0)
                return;
            if (v < 1)
                v = 1;
            if (v > RING_SLOTS)
                v = RING_SLOTS;
            capacity  = v;
            head_slot = 0;
            tail_slot = 0;
        endfunction

        function void reverse_words();
            int unsigned       lo;
            int unsigned       hi;
            logic [WORD_W-1:0] tmp;
            lo = head_slot;
            hi = prev_slot(tail_slot);
            for (int k = 0; k < stored_count / 2; k++)
            begin
                tmp            = ring_words[lo];
                ring_words[lo] = ring_words[hi];
                ring_words[hi] = tmp;
                lo = next_slot(lo);
                hi = prev_slot(hi);
            end
        endfunction

        // apply one accepted request and queue up the result it should give
        function void note_request(logic [CMD_W-1:0] op, logic [WORD_W-1:0] word);
            queue_result_t r;
            r.status   = ST_DONE;
            r.data_out = '1;
            if (op == CMD_ENQ)
            begin
                if (stored_count >= capacity)
                    r.status = ST_FULL;
                else
                begin
                    ring_words[tail_slot] = word;
                    tail_slot = next_slot(tail_slot);
                    stored_count++;
                end
            end
            else if (op == CMD_DEQ)
            begin
                if (stored_count == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    r.data_out = ring_words[head_slot];
                    head_slot  = next_slot(head_slot);
                    stored_count--;
                end
            end
            else if (op == CMD_REV)
            begin
                if (stored_count == 0)
                    r.status = ST_EMPTY;
                else
                    reverse_words();
            end
            r.head_value = (stored_count == 0) ? '1 : ring_words[head_slot];
            r.is_empty   = (stored_count == 0);
            r.is_full    = (stored_count == capacity);
            r.occupancy  = OCC_W'(stored_count);
            awaited_results.push_back(r);
        endfunction

        function void compare_field(string field, logic [WORD_W-1:0] expected,
                                    logic [WORD_W-1:0] actual);
            if (actual !== expected)
            begin
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, field, expected, actual);
                errors++;
            end
        endfunction

        function void check_result(queue_result_t got);
            queue_result_t want;
            if (awaited_results.size() == 0)
            begin
                $display("%0t: result with none outstanding, expected none, actual %0h",
                         $time, got);
                errors++;
                return;
            end
            want = awaited_results.pop_front();
            compare_field("status", WORD_W'(want.status), WORD_W'(got.status));
            compare_field("data_out", want.data_out, got.data_out);
            compare_field("head_value", want.head_value, got.head_value);
            compare_field("is_empty", WORD_W'(want.is_empty), WORD_W'(got.is_empty));
            compare_field("is_full", WORD_W'(want.is_full), WORD_W'(got.is_full));
            compare_field("occupancy", WORD_W'(want.occupancy), WORD_W'(got.occupancy));
        endfunction

    endclass

endpackage

// ===== dv/tb_top.sv =====
// top-level testbench for the circular queue with reverse
`timescale 1ns / 100ps

module tb_top;

    import cqr_pkg::*;
    import cq_scoreboard_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'd3;
    localparam int               STALL_LIMIT = 2000;
    localparam int               PHASE_ITEMS = 48;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                start     = 1'b0;
    logic [CMD_W-1:0]    cmd       = CMD_ENQ;
    logic [WORD_W-1:0]   data_in   = '0;
    logic                cfg_valid = 1'b0;
    logic [CFG_W-1:0]    cfg_data  = '0;
    logic                busy;
    logic                cfg_ready;
    logic                done;
    logic [STAT_W-1:0]   status;
    logic [WORD_W-1:0]   data_out;
    logic [WORD_W-1:0]   head_value;
    logic                is_empty;
    logic                is_full;
    logic [OCC_W-1:0]    occupancy;

    cq_scoreboard sb;
    int unsigned  stall_cycles = 0;

    circular_queue_with_reverse #(
        .DEPTH      (RING_SLOTS),
        .DATA_WIDTH (WORD_W)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .data_in    (data_in),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .done       (done),
        .status     (status),
        .data_out   (data_out),
        .head_value (head_value),
        .is_empty   (is_empty),
        .is_full    (is_full),
        .occupancy  (occupancy)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result check and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_result('{status, data_out, head_value, is_empty, is_full, occupancy});
            if ((start && !busy) || done || (cfg_valid && cfg_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // start stays high into the next request unless a gap is taken
    task automatic send_request(input logic [CMD_W-1:0] op, input logic [WORD_W-1:0] word,
                                input int unsigned idle_pct);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        start   <= 1'b1;
        cmd     <= op;
        data_in <= word;
        do @(posedge clk); while (busy);
        sb.note_request(op, word);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (sb.awaited_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CFG_W-1:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        sb.set_capacity(value);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain_queue(input int unsigned idle_pct);
        while (sb.stored_count != 0)
            send_request(CMD_DEQ, pick_word(), idle_pct);
    endtask

    task automatic random_phase(input int unsigned idle_pct);
        int unsigned      enq_weight;
        int unsigned      roll;
        logic [CMD_W-1:0] op;
        enq_weight = 50;
        for (int i = 0; i < PHASE_ITEMS; i++)
        begin
            // swing the fill level so both full and empty get reached
            if (i % 14 == 0)
                enq_weight = $urandom_range(25, 75);
            roll = $urandom_range(99);
            if (roll < enq_weight)
                op = CMD_ENQ;
            else if (roll < 86)
                op = CMD_DEQ;
            else if (roll < 97)
                op = CMD_REV;
            else
                op = CMD_UNUSED;
            send_request(op, pick_word(), idle_pct);
        end
    endtask

    initial
    begin
        logic [CFG_W-1:0] cap_list [9];
        int unsigned      idle_list [3];
        cap_list  = '{4'd0, 4'd1, 4'd8, 4'd15, 4'd3, 4'd5, 4'd2, 4'd9, 4'd4};
        idle_list = '{0, 45, 14};
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty queue corners
        send_request(CMD_DEQ, 32'h1234_5678, 0);
        send_request(CMD_REV, '0, 0);
        send_request(CMD_UNUSED, '1, 0);
        // single word reverse, then fill to the top with extreme words
        send_request(CMD_ENQ, 32'h7FFF_FFFF, 0);
        send_request(CMD_REV, '0, 0);
        send_request(CMD_ENQ, 32'h8000_0000, 0);
        send_request(CMD_ENQ, 32'hFFFF_FFFF, 0);
        send_request(CMD_ENQ, 32'h0000_0000, 0);
        send_request(CMD_ENQ, 32'h0000_0001, 0);
        send_request(CMD_ENQ, 32'h5555_5555, 0);
        send_request(CMD_ENQ, 32'hAAAA_AAAA, 0);
        send_request(CMD_ENQ, 32'd12345, 0);
        send_request(CMD_ENQ, 32'hDEAD_BEEF, 0);
        // even and odd count reverses
        send_request(CMD_REV, '0, 0);
        send_request(CMD_DEQ, '0, 0);
        send_request(CMD_REV, '0, 0);
        send_request(CMD_UNUSED, 32'h0F0F_0F0F, 0);
        // capacity write with words stored is ignored
        write_capacity(4'd3);
        drain_queue(0);
        send_request(CMD_DEQ, '1, 0);

        foreach (cap_list[p])
        begin
            drain_queue(idle_list[p % 3]);
            write_capacity(cap_list[p]);
            random_phase(idle_list[p % 3]);
        end

        wait_idle();
        repeat (30) @(posedge clk);
        if (sb.errors == 0 && sb.awaited_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
